// ===== hw/rtl/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// Types, sizes and operation codes shared by the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int ITEM_W    = 10;
  localparam int KEY_W     = 32;
  localparam int SLOT_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_ERASE  = 2'd1;
  localparam logic [1:0] FN_UPDATE = 2'd2;
  localparam logic [1:0] FN_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [ITEM_W-1:0] item;
    logic [KEY_W-1:0]  key;
  } in_t;

  typedef struct packed {
    logic [ITEM_W-1:0] top_item;
    logic [KEY_W-1:0]  top_key;
    logic              is_empty;
    logic [CNT_W-1:0]  entry_count;
    logic              error;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item;
  } entry_t;

endpackage

// ===== hw/rtl/imh_less.sv =====
// ----------------------------------------------------------------------------
// imh_less
// Heap order compare: smaller key first, ties to the smaller item number.
// ----------------------------------------------------------------------------
module imh_less (
  input  imh_pkg::entry_t a,
  input  imh_pkg::entry_t b,
  output logic            a_lt_b
);

  always_comb begin
    if (a.key != b.key) begin
      a_lt_b = a.key < b.key;
    end else begin
      a_lt_b = a.item < b.item;
    end
  end

endmodule

// ===== hw/rtl/imh_engine.sv =====
// ----------------------------------------------------------------------------
// imh_engine
// Sequencer that walks the heap one level at a time through the slot memory
// and the position table, sharing one order comparator.
// ----------------------------------------------------------------------------
module imh_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  imh_pkg::in_t  start_word,
  output logic          ready,
  output logic          done,
  output imh_pkg::out_t result
);

  typedef enum logic [13:0] {
    S_INIT     = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_LOOKUP   = 14'b00000000000100,
    S_CHECK    = 14'b00000000001000,
    S_ERLOAD   = 14'b00000000010000,
    S_RISE     = 14'b00000000100000,
    S_RISE_CMP = 14'b00000001000000,
    S_SINK     = 14'b00000010000000,
    S_SINK_L   = 14'b00000100000000,
    S_SINK_R   = 14'b00001000000000,
    S_SINK_CMP = 14'b00010000000000,
    S_FINAL    = 14'b00100000000000,
    S_TOP      = 14'b01000000000000,
    S_TOPRD    = 14'b10000000000000
  } state_t;

  localparam int SW = imh_pkg::SLOT_W;
  localparam int CW = imh_pkg::CNT_W;

  // slot memory and position table
  imh_pkg::entry_t heap_mem [imh_pkg::MAX_ITEMS];
  logic [SW-1:0]   pos_mem  [imh_pkg::MAX_ITEMS];

  state_t                      state_r, state_nxt;
  logic [1:0]                  func_r, func_nxt;
  logic [imh_pkg::ITEM_W-1:0]  item_r, item_nxt;
  logic [imh_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [CW-1:0]               size_r, size_nxt;
  logic [SW-1:0]               pos_r, pos_nxt;
  logic [SW-1:0]               pick_r, pick_nxt;
  imh_pkg::entry_t             e_r, e_nxt;
  imh_pkg::entry_t             c_r, c_nxt;
  logic                        try_sink_r, try_sink_nxt;
  logic                        err_r, err_nxt;
  logic [SW-1:0]               init_cnt_r, init_cnt_nxt;

  logic            h_we, p_we;
  logic [SW-1:0]   h_wa, h_ra, p_wa, p_ra;
  imh_pkg::entry_t h_wd, h_rd;
  logic [SW-1:0]   p_wd, p_rd;

  imh_pkg::entry_t cmp_a, cmp_b;
  logic            cmp_lt;

  logic [SW-1:0]   parent;
  logic [CW:0]     lchild, rchild;
  logic            present;

  always_ff @(posedge clk) begin
    if (h_we) begin
      heap_mem[h_wa] <= h_wd;
    end
    h_rd <= heap_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pos_mem[p_wa] <= p_wd;
    end
    p_rd <= pos_mem[p_ra];
  end

  imh_less u_less (
    .a      (cmp_a),
    .b      (cmp_b),
    .a_lt_b (cmp_lt)
  );

  assign parent  = SW'((pos_r - SW'(1)) >> 1);
  assign lchild  = {1'b0, pos_r, 1'b1};
  assign rchild  = lchild + (CW + 1)'(1);
  // an item is held only if its table entry points at a live slot holding it
  assign present = ({1'b0, pos_r} < size_r) && (h_rd.item == item_r);

  always_comb begin
    cmp_a = e_r;
    cmp_b = h_rd;
    case (state_r)
      S_SINK_R: begin
        cmp_a = h_rd;
        cmp_b = c_r;
      end
      S_SINK_CMP: begin
        cmp_a = c_r;
        cmp_b = e_r;
      end
      default: begin
        cmp_a = e_r;
        cmp_b = h_rd;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    item_nxt     = item_r;
    key_nxt      = key_r;
    size_nxt     = size_r;
    pos_nxt      = pos_r;
    pick_nxt     = pick_r;
    e_nxt        = e_r;
    c_nxt        = c_r;
    try_sink_nxt = try_sink_r;
    err_nxt      = err_r;
    init_cnt_nxt = init_cnt_r;
    h_we = 1'b0;
    h_wa = pos_r;
    h_wd = e_r;
    h_ra = '0;
    p_we = 1'b0;
    p_wa = e_r.item[SW-1:0];
    p_wd = pos_r;
    p_ra = item_r[SW-1:0];
    done = 1'b0;

    case (state_r)
      S_INIT: begin
        p_we = 1'b1;
        p_wa = init_cnt_r;
        p_wd = '0;
        init_cnt_nxt = init_cnt_r + SW'(1);
        if (init_cnt_r == SW'(imh_pkg::MAX_ITEMS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          func_nxt = start_word.func;
          item_nxt = start_word.item;
          key_nxt  = start_word.key;
          err_nxt  = 1'b0;
          p_ra     = start_word.item[SW-1:0];
          if (start_word.func == imh_pkg::FN_CLEAR) begin
            size_nxt  = '0;
            state_nxt = S_TOP;
          end else begin
            state_nxt = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        pos_nxt   = p_rd;
        h_ra      = p_rd;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_TOP;
        case (func_r)
          imh_pkg::FN_INSERT: begin
            if (present || size_r == CW'(imh_pkg::MAX_ITEMS)) begin
              err_nxt = 1'b1;
            end else begin
              e_nxt        = '{key: key_r, item: item_r};
              pos_nxt      = size_r[SW-1:0];
              size_nxt     = size_r + CW'(1);
              try_sink_nxt = 1'b0;
              state_nxt    = S_RISE;
            end
          end
          imh_pkg::FN_ERASE: begin
            if (!present) begin
              err_nxt = 1'b1;
            end else begin
              size_nxt = size_r - CW'(1);
              h_ra     = SW'(size_r - CW'(1));
              if ({1'b0, pos_r} != size_r - CW'(1)) begin
                state_nxt = S_ERLOAD;
              end
            end
          end
          imh_pkg::FN_UPDATE: begin
            if (!present) begin
              err_nxt = 1'b1;
            end else begin
              e_nxt        = '{key: key_r, item: item_r};
              try_sink_nxt = 1'b0;
              if (key_r < h_rd.key) begin
                state_nxt = S_RISE;
              end else if (key_r > h_rd.key) begin
                state_nxt = S_SINK;
              end
            end
          end
          default: begin
            state_nxt = S_TOP;
          end
        endcase
      end
      S_ERLOAD: begin
        // last entry fills the hole; it may go either way
        e_nxt        = h_rd;
        try_sink_nxt = 1'b1;
        state_nxt    = S_RISE;
      end
      S_RISE: begin
        h_ra = parent;
        if (pos_r == '0) begin
          state_nxt = try_sink_r ? S_SINK : S_FINAL;
        end else begin
          state_nxt = S_RISE_CMP;
        end
      end
      S_RISE_CMP: begin
        if (cmp_lt) begin
          h_we         = 1'b1;
          h_wa         = pos_r;
          h_wd         = h_rd;
          p_we         = 1'b1;
          p_wa         = h_rd.item[SW-1:0];
          p_wd         = pos_r;
          pos_nxt      = parent;
          try_sink_nxt = 1'b0;
          state_nxt    = S_RISE;
        end else begin
          state_nxt = try_sink_r ? S_SINK : S_FINAL;
        end
      end
      S_SINK: begin
        h_ra = lchild[SW-1:0];
        if (lchild >= {1'b0, size_r}) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_SINK_L;
        end
      end
      S_SINK_L: begin
        c_nxt    = h_rd;
        pick_nxt = lchild[SW-1:0];
        h_ra     = rchild[SW-1:0];
        if (rchild < {1'b0, size_r}) begin
          state_nxt = S_SINK_R;
        end else begin
          state_nxt = S_SINK_CMP;
        end
      end
      S_SINK_R: begin
        if (cmp_lt) begin
          c_nxt    = h_rd;
          pick_nxt = pick_r + SW'(1);
        end
        state_nxt = S_SINK_CMP;
      end
      S_SINK_CMP: begin
        if (cmp_lt) begin
          h_we      = 1'b1;
          h_wa      = pos_r;
          h_wd      = c_r;
          p_we      = 1'b1;
          p_wa      = c_r.item[SW-1:0];
          p_wd      = pos_r;
          pos_nxt   = pick_r;
          state_nxt = S_SINK;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        h_we      = 1'b1;
        p_we      = 1'b1;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        h_ra      = '0;
        state_nxt = S_TOPRD;
      end
      S_TOPRD: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    result.is_empty    = (size_r == '0);
    result.entry_count = size_r;
    result.error       = err_r;
    result.top_item    = result.is_empty ? '0 : h_rd.item;
    result.top_key     = result.is_empty ? '0 : h_rd.key;
  end

  assign ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      size_r     <= '0;
      init_cnt_r <= '0;
      try_sink_r <= 1'b0;
      err_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      size_r     <= size_nxt;
      init_cnt_r <= init_cnt_nxt;
      try_sink_r <= try_sink_nxt;
      err_r      <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    item_r <= item_nxt;
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    pick_r <= pick_nxt;
    e_r    <= e_nxt;
    c_r    <= c_nxt;
  end

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CW'(imh_pkg::MAX_ITEMS))
    else $error("heap count beyond capacity");

  a_rise_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RISE_CMP |-> pos_r != '0)
    else $error("parent compare at root slot");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle");

  a_err_keeps_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && state_nxt == S_TOP && err_nxt) |=> $stable(size_r))
    else $error("refused operation changed count");

endmodule

// ===== hw/rtl/indexed_min_heap_top.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_top
// Indexed binary min-heap of (key, item) entries with an item position table.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one operation word (insert, erase,
//   update key, clear). A word is taken when in_valid is high and in_stall
//   low. Each operation yields one result word on out_valid/out_data:
//   top item and key, empty flag, entry count and a refusal flag.
//   A clear goes from idle straight to the read of the top slot; a refused
//   operation, an equal-key update or an erase of the last entry passes
//   through lookup and check first. Sifts move one level per round of
//   slot reads and compares (an erase that refills the hole first loads the
//   last entry), set by the single read port of the slot memory, which
//   supplies one entry per cycle. One operation is in flight at a time;
//   in_stall is high while the sequencer works and while a result word
//   still waits in the output register, so the next word is taken at the
//   earliest in the cycle after the result is taken. After reset all 1024
//   position table entries are cleared with in_stall high. A stalled
//   result word holds until taken.
// ----------------------------------------------------------------------------
module indexed_min_heap_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  imh_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output imh_pkg::out_t out_data
);

  logic          eng_ready;
  logic          eng_done;
  logic          start;
  imh_pkg::out_t eng_result;
  logic          out_valid_r, out_valid_nxt;
  imh_pkg::out_t out_data_r;

  assign in_stall = !eng_ready || out_valid_r;
  assign start    = in_valid && !in_stall;

  imh_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_word (in_data),
    .ready      (eng_ready),
    .done       (eng_done),
    .result     (eng_result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (eng_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_data_r <= eng_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> !out_valid_r)
    else $error("result word overwritten");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("second word taken during operation");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> eng_ready && !out_valid_r)
    else $error("word taken while busy");

endmodule

// ===== verif/tb_indexed_min_heap_top.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_top
// Random and directed heap operations against a behavioral heap predictor.
// Every result word is checked field by field against the predicted word.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_top;
  timeunit 1ns;
  timeprecision 1ps;

  class heap_scoreboard;
    imh_pkg::entry_t slots[imh_pkg::MAX_ITEMS];
    bit              present[imh_pkg::MAX_ITEMS];
    int              slot_of[imh_pkg::MAX_ITEMS];
    int              count;
    imh_pkg::out_t   pending[$];
    int              fails;
    int              checked;
    int              refused;

    function void clear_all();
      foreach (present[i]) present[i] = 0;
      count = 0;
    endfunction

    function bit ent_lt(imh_pkg::entry_t a, imh_pkg::entry_t b);
      if (a.key != b.key) return a.key < b.key;
      return a.item < b.item;
    endfunction

    function void put(int pos, imh_pkg::entry_t e);
      slots[pos] = e;
      slot_of[e.item] = pos;
    endfunction

    function void sift_up(int pos);
      imh_pkg::entry_t e;
      int up;
      e = slots[pos];
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (!ent_lt(e, slots[up])) break;
        put(pos, slots[up]);
        pos = up;
      end
      put(pos, e);
    endfunction

    function void sink_at(int pos);
      imh_pkg::entry_t e;
      int l, pick;
      e = slots[pos];
      forever begin
        l = 2 * pos + 1;
        if (l >= count) break;
        pick = l;
        if (l + 1 < count && ent_lt(slots[l + 1], slots[l])) pick = l + 1;
        if (!ent_lt(slots[pick], e)) break;
        put(pos, slots[pick]);
        pos = pick;
      end
      put(pos, e);
    endfunction

    // apply one accepted operation word and queue the predicted result
    function void note_op(imh_pkg::in_t w);
      imh_pkg::out_t r;
      imh_pkg::entry_t e;
      int pos, last;
      logic [imh_pkg::KEY_W-1:0] old;
      bit err;
      err = 0;
      case (w.func)
        imh_pkg::FN_INSERT: begin
          if (present[w.item] || count >= imh_pkg::MAX_ITEMS) err = 1;
          else begin
            e.key = w.key;
            e.item = w.item;
            present[w.item] = 1;
            put(count, e);
            count++;
            sift_up(count - 1);
          end
        end
        imh_pkg::FN_ERASE: begin
          if (!present[w.item] || count == 0) err = 1;
          else begin
            pos = slot_of[w.item];
            last = count - 1;
            present[w.item] = 0;
            count = last;
            if (pos < last) begin
              put(pos, slots[last]);
              if (pos > 0 && ent_lt(slots[pos], slots[(pos - 1) / 2])) sift_up(pos);
              else sink_at(pos);
            end
          end
        end
        imh_pkg::FN_UPDATE: begin
          if (!present[w.item]) err = 1;
          else begin
            pos = slot_of[w.item];
            old = slots[pos].key;
            slots[pos].key = w.key;
            if (w.key < old) sift_up(pos);
            else if (w.key > old) sink_at(pos);
          end
        end
        default: clear_all();
      endcase
      if (err) refused++;
      r.top_item = count > 0 ? slots[0].item : '0;
      r.top_key = count > 0 ? slots[0].key : '0;
      r.is_empty = (count == 0);
      r.entry_count = imh_pkg::CNT_W'(count);
      r.error = err;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(imh_pkg::out_t got);
      imh_pkg::out_t exp;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        fails++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.top_item !== exp.top_item) begin
        $error("top_item exp %0d got %0d", exp.top_item, got.top_item); fails++;
      end
      if (got.top_key !== exp.top_key) begin
        $error("top_key exp %0h got %0h", exp.top_key, got.top_key); fails++;
      end
      if (got.is_empty !== exp.is_empty) begin
        $error("is_empty exp %0b got %0b", exp.is_empty, got.is_empty); fails++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count exp %0d got %0d", exp.entry_count, got.entry_count); fails++;
      end
      if (got.error !== exp.error) begin
        $error("error exp %0b got %0b", exp.error, got.error); fails++;
      end
    endfunction
  endclass

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0;
  logic          in_stall;
  imh_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 0;
  imh_pkg::out_t out_data;

  heap_scoreboard sb = new();
  int fill_ops = 0;
  int stall_left = 0;

  always #10 clk = ~clk;

  indexed_min_heap_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one word and hold it until taken; valid drops only for a gap
  task automatic send_word(logic [1:0] f, int it, logic [imh_pkg::KEY_W-1:0] k);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{func: f, item: it[imh_pkg::ITEM_W-1:0], key: k};
    do @(posedge clk); while (in_stall);
    sb.note_op(in_data);
  endtask

  function logic [imh_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return '1 - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // output side: stall bursts of random length, checking each accepted word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= 1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 0;
    end
  end

  initial begin
    int n, it, live;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    // directed part
    send_word(imh_pkg::FN_ERASE, 5, 0);
    send_word(imh_pkg::FN_UPDATE, 5, 1);
    send_word(imh_pkg::FN_INSERT, 1023, '1);
    send_word(imh_pkg::FN_INSERT, 0, '1);
    send_word(imh_pkg::FN_INSERT, 0, 3);
    send_word(imh_pkg::FN_INSERT, 7, 0);
    send_word(imh_pkg::FN_INSERT, 8, 0);
    send_word(imh_pkg::FN_UPDATE, 8, 0);
    send_word(imh_pkg::FN_UPDATE, 1023, 0);
    send_word(imh_pkg::FN_UPDATE, 7, 32'h5555_AAAA);
    send_word(imh_pkg::FN_UPDATE, 7, 32'hAAAA_5555);
    send_word(imh_pkg::FN_ERASE, 1023, 0);
    send_word(imh_pkg::FN_ERASE, 1023, 0);
    send_word(imh_pkg::FN_ERASE, 8, 0);
    send_word(imh_pkg::FN_CLEAR, 1023, '1);
    send_word(imh_pkg::FN_ERASE, 0, 0);
    // deep fill, a duplicate, then drain some
    for (it = 0; it < 320; it++) begin
      send_word(imh_pkg::FN_INSERT, it ^ 10'h2A5, rand_key());
      fill_ops++;
    end
    send_word(imh_pkg::FN_INSERT, 10'h2A5, 0);
    for (it = 0; it < 20; it++) send_word(imh_pkg::FN_ERASE, $urandom_range(0, 1023), 0);
    send_word(imh_pkg::FN_CLEAR, 0, 0);
    // random part: mostly small item pool so hits are common
    for (n = 0; n < 540; n++) begin
      live = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
      case ($urandom_range(0, 99))
        0, 1: send_word(imh_pkg::FN_CLEAR, $urandom_range(0, 1023), $urandom);
        default: begin
          if ($urandom_range(0, 99) < 45) send_word(imh_pkg::FN_INSERT, live, rand_key());
          else if ($urandom_range(0, 1)) send_word(imh_pkg::FN_ERASE, live, $urandom);
          else send_word(imh_pkg::FN_UPDATE, live, rand_key());
        end
      endcase
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d checked results (%0d refused), incl. a fill of %0d entries.",
             sb.checked, sb.refused, fill_ops);
    if (sb.fails == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
